FILE: src/idi_chi2_running_score_core_assert.svh
// Assertion macros for the interval score core.
// Both expect the clock aclk and the active-low reset aresetn in scope.
`ifndef IDI_CHI2_RUNNING_SCORE_CORE_ASSERT_SVH
`define IDI_CHI2_RUNNING_SCORE_CORE_ASSERT_SVH

// Same-cycle implication.
`define IDI_C2_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IDI_C2_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/idi_c2_pkg.sv
`timescale 1ns / 1ps

package idi_c2_pkg;

    // Field and register widths.
    localparam int TIME_W     = 63;
    localparam int BITS_W     = 16;
    localparam int SCORE_W    = 32;
    localparam int SUM_W      = 48;
    localparam int IVL_W      = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;
    localparam int MINIVL_W   = 40;
    localparam int RELERR_W   = 24;
    localparam int MINERR_W   = 40;
    localparam int JUNK_W     = 32;

    // Shared serial units: one bit of the multiplier or quotient per step.
    localparam int STEPS  = 32;
    localparam int STEP_W = 5;
    localparam int MC_W   = 48;
    localparam int MP_W   = STEPS;
    localparam int PROD_W = MC_W + MP_W;
    localparam int QUO_W  = STEPS;
    localparam int DREM_W = 56;
    localparam int ERR_W  = 55;

    typedef logic [STEP_W-1:0] step_t;
    localparam step_t STEP_LAST = step_t'(STEPS - 1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_INTERVAL = 2'd0,
        CFG_REL_ERROR    = 2'd1,
        CFG_MIN_ERROR    = 2'd2,
        CFG_JUNK_PENALTY = 2'd3
    } cfg_idx_t;

endpackage

FILE: src/idi_c2_smul.sv
`timescale 1ns / 1ps

module idi_c2_smul (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [idi_c2_pkg::MC_W-1:0]    mcand,
    input  logic [idi_c2_pkg::MP_W-1:0]    mplier,
    output logic [idi_c2_pkg::PROD_W-1:0]  product,
    output logic                           done
);

    logic                          busy_reg;
    logic                          done_reg;
    idi_c2_pkg::step_t             cnt_reg;
    logic [idi_c2_pkg::MC_W-1:0]   mcand_reg;
    logic [idi_c2_pkg::PROD_W-1:0] prod_reg;
    logic [idi_c2_pkg::MC_W:0]     part_sum;
    logic [idi_c2_pkg::PROD_W-1:0] prod_next;

    // One multiplier bit per step: add into the upper half, shift right.
    always_comb begin
        part_sum  = {1'b0, prod_reg[idi_c2_pkg::PROD_W-1:idi_c2_pkg::MP_W]}
                  + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        prod_next = {part_sum, prod_reg[idi_c2_pkg::MP_W-1:1]};
    end

    // Step counter and completion pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == idi_c2_pkg::STEP_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial product registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg <= mcand;
            prod_reg  <= {{idi_c2_pkg::MC_W{1'b0}}, mplier};
        end else if (busy_reg) begin
            prod_reg <= prod_next;
        end
    end

    assign product = prod_reg;
    assign done    = done_reg;

endmodule

FILE: src/idi_c2_qdiv.sv
`timescale 1ns / 1ps

module idi_c2_qdiv (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [idi_c2_pkg::DREM_W-1:0]  rem_init,
    input  logic [idi_c2_pkg::QUO_W-1:0]   num_lo,
    input  logic [idi_c2_pkg::DREM_W-1:0]  divisor,
    output logic [idi_c2_pkg::QUO_W-1:0]   quotient,
    output logic                           done
);

    logic                          busy_reg;
    logic                          done_reg;
    idi_c2_pkg::step_t             cnt_reg;
    logic [idi_c2_pkg::DREM_W-1:0] rem_reg;
    logic [idi_c2_pkg::DREM_W-1:0] div_reg;
    logic [idi_c2_pkg::QUO_W-1:0]  q_reg;
    logic [idi_c2_pkg::DREM_W-1:0] trial;
    logic                          fits;

    // Restoring step: bring down the next numerator bit, subtract if it fits.
    // The caller guarantees that the starting remainder is below the divisor.
    always_comb begin
        trial = {rem_reg[idi_c2_pkg::DREM_W-2:0], q_reg[idi_c2_pkg::QUO_W-1]};
        fits  = (trial >= div_reg);
    end

    // Step counter and completion pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == idi_c2_pkg::STEP_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and numerator/quotient shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init;
            div_reg <= divisor;
            q_reg   <= num_lo;
        end else if (busy_reg) begin
            rem_reg <= fits ? (trial - div_reg) : trial;
            q_reg   <= {q_reg[idi_c2_pkg::QUO_W-2:0], fits};
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

FILE: src/idi_chi2_running_score_core.sv
`timescale 1ns / 1ps
// A clear or a restarting unit goes straight to its result. A tracked unit runs the bit-serial
// ms remainder, then a 32-step quotient and a 32-step square (skipped for a first interval, a
// short gap or a saturated ratio); it and an untracked unit end in a 32-step normalizing
// quotient (skipped if the score saturates). Results held off by m_ready wait in S_DONE.
// Throughput: one word in work at a time; the next word is taken once the result is in the
// output register. Configuration writes are taken every cycle.
// Reset (aresetn low, synchronous) clears the score state and loads the register defaults.
`include "idi_chi2_running_score_core_assert.svh"

module idi_chi2_running_score_core (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic [idi_c2_pkg::TIME_W-1:0]      s_unit_time,
    input  logic                               s_in_track,
    input  logic [idi_c2_pkg::BITS_W-1:0]      s_bit_count,
    input  logic [idi_c2_pkg::BITS_W-1:0]      s_k_count,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [idi_c2_pkg::SCORE_W-1:0]     m_score_q16,
    output logic                               m_overflow,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [idi_c2_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [idi_c2_pkg::CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_MOD       = 12'b0000_0000_0010,
        S_IVL       = 12'b0000_0000_0100,
        S_NOW       = 12'b0000_0000_1000,
        S_TERM      = 12'b0000_0001_0000,
        S_CHK       = 12'b0000_0010_0000,
        S_DIV       = 12'b0000_0100_0000,
        S_SQR       = 12'b0000_1000_0000,
        S_ACC       = 12'b0001_0000_0000,
        S_NORM_CHK  = 12'b0010_0000_0000,
        S_NORM      = 12'b0100_0000_0000,
        S_DONE      = 12'b1000_0000_0000
    } state_t;

    localparam int MSR_W    = 20;
    localparam int MS_CNT_W = 6;
    localparam logic [MSR_W:0]          MS_DIV    = 21'd1000000;
    localparam logic [MS_CNT_W-1:0]     MS_LAST   = 6'd62;
    localparam logic [47:0]             SUM_MAX   = {48{1'b1}};
    localparam logic [31:0]             SCORE_MAX = {32{1'b1}};
    localparam logic [47:0]             IVL_MAX   = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0]             IVL_MIN   = 48'h8000_0000_0000;
    localparam logic signed [63:0]      NEG_FLOOR = 64'shFFFF_8000_0000_0000;

    // Configuration registers.
    logic [idi_c2_pkg::MINIVL_W-1:0] min_ivl_reg;
    logic [idi_c2_pkg::RELERR_W-1:0] rel_err_reg;
    logic [idi_c2_pkg::MINERR_W-1:0] min_err_reg;
    logic [idi_c2_pkg::JUNK_W-1:0]   junk_reg;

    // Score state.
    logic [idi_c2_pkg::SUM_W-1:0]    sum_reg;
    logic [idi_c2_pkg::IVL_W-1:0]    prev_ivl_reg;
    logic                            pvalid_reg;
    logic                            have_prev_reg;
    logic [idi_c2_pkg::TIME_W-1:0]   ptime_reg;

    // Control.
    state_t                          state_reg;
    logic [MS_CNT_W-1:0]             cnt_reg;
    logic                            m_valid_reg;

    // Work registers.
    logic [idi_c2_pkg::TIME_W-1:0]   t_reg;
    logic [idi_c2_pkg::BITS_W-1:0]   bits_reg;
    logic [idi_c2_pkg::TIME_W-1:0]   sh_p_reg;
    logic [idi_c2_pkg::TIME_W-1:0]   sh_t_reg;
    logic [MSR_W-1:0]                rp_reg;
    logic [MSR_W-1:0]                rt_reg;
    logic [idi_c2_pkg::TIME_W-1:0]   pa_reg;
    logic [idi_c2_pkg::TIME_W-1:0]   ta_reg;
    logic [idi_c2_pkg::TIME_W-1:0]   dpos_reg;
    logic                            ge_reg;
    logic [idi_c2_pkg::IVL_W-1:0]    now_reg;
    logic [47:0]                     a_reg;
    logic [idi_c2_pkg::ERR_W-1:0]    e_reg;
    logic [idi_c2_pkg::SUM_W-1:0]    term_reg;
    logic [idi_c2_pkg::SCORE_W-1:0]  res_score_reg;
    logic                            res_ovf_reg;
    logic [idi_c2_pkg::SCORE_W-1:0]  m_score_reg;
    logic                            m_ovf_reg;

    // Combinational helpers.
    logic                            accept;
    logic                            restart;
    logic                            out_free;
    logic                            out_load;
    logic [63:0]                     neg;
    logic [idi_c2_pkg::IVL_W-1:0]    now_pos;
    logic [idi_c2_pkg::IVL_W-1:0]    now_neg;
    logic [idi_c2_pkg::IVL_W-1:0]    now_val;
    logic [48:0]                     d_fwd;
    logic [48:0]                     d_bwd;
    logic                            last_pos;
    logic [idi_c2_pkg::MINERR_W-1:0] min_eff;
    logic [idi_c2_pkg::ERR_W-1:0]    p_err;
    logic                            junk;
    logic                            sat_div;
    logic                            sat_norm;
    logic [idi_c2_pkg::SUM_W:0]      sum_add;

    // Shared unit connections.
    logic                            smul_start;
    logic [idi_c2_pkg::MC_W-1:0]     smul_mcand;
    logic [idi_c2_pkg::MP_W-1:0]     smul_mplier;
    logic [idi_c2_pkg::PROD_W-1:0]   smul_prod;
    logic                            smul_done;
    logic                            qdiv_start;
    logic [idi_c2_pkg::DREM_W-1:0]   qdiv_rem;
    logic [idi_c2_pkg::QUO_W-1:0]    qdiv_lo;
    logic [idi_c2_pkg::DREM_W-1:0]   qdiv_div;
    logic [idi_c2_pkg::QUO_W-1:0]    qdiv_quot;
    logic                            qdiv_done;

    // One bit of a restoring division by one million.
    function automatic logic [MSR_W-1:0] ms_step(input logic [MSR_W-1:0] rem,
                                                 input logic din);
        logic [MSR_W:0] trial;
        logic [MSR_W:0] diff;
        trial = {rem, din};
        diff  = trial - MS_DIV;
        if (trial >= MS_DIV) begin
            return diff[MSR_W-1:0];
        end
        return trial[MSR_W-1:0];
    endfunction

    // Handshakes.
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign restart   = !have_prev_reg || (s_k_count < 16'd2) || (s_bit_count < 16'd2);
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = (state_reg == S_DONE) && out_free;

    // New interval: forward difference, or whole-millisecond difference going back.
    always_comb begin
        neg     = {1'b0, ta_reg} - {1'b0, pa_reg};
        now_pos = (|dpos_reg[62:47]) ? IVL_MAX : dpos_reg[47:0];
        now_neg = ($signed(neg) < NEG_FLOOR) ? IVL_MIN : neg[47:0];
        now_val = ge_reg ? now_pos : now_neg;
    end

    // Interval error and deviation magnitude.
    always_comb begin
        d_fwd    = {now_reg[47], now_reg} - {prev_ivl_reg[47], prev_ivl_reg};
        d_bwd    = {prev_ivl_reg[47], prev_ivl_reg} - {now_reg[47], now_reg};
        last_pos = !prev_ivl_reg[47] && (|prev_ivl_reg);
        min_eff  = (min_err_reg == '0) ? 40'd1 : min_err_reg;
        p_err    = smul_prod[70:16];
    end

    // Saturation tests ahead of each quotient.
    always_comb begin
        junk     = $signed(now_reg) < $signed({8'b0, min_ivl_reg});
        sat_div  = {23'b0, a_reg} >= {e_reg, 16'b0};
        sat_norm = sum_reg >= {bits_reg, 32'b0};
        sum_add  = {1'b0, sum_reg} + {1'b0, term_reg};
    end

    // The multiplier forms last * relative error during the remainder pass,
    // then the square of the quotient.
    always_comb begin
        smul_start = (accept && !s_action && s_in_track && !restart)
                   || ((state_reg == S_DIV) && qdiv_done);
        if (state_reg == S_IDLE) begin
            smul_mcand  = last_pos ? prev_ivl_reg : '0;
            smul_mplier = {8'b0, rel_err_reg};
        end else begin
            smul_mcand  = {16'b0, qdiv_quot};
            smul_mplier = qdiv_quot;
        end
    end

    // The divider forms deviation / error, then score sum / bit count.
    always_comb begin
        qdiv_start = ((state_reg == S_CHK) && !junk && !sat_div)
                   || ((state_reg == S_NORM_CHK) && !sat_norm);
        if (state_reg == S_CHK) begin
            qdiv_rem = {24'b0, a_reg[47:16]};
            qdiv_lo  = {a_reg[15:0], 16'b0};
            qdiv_div = {1'b0, e_reg};
        end else begin
            qdiv_rem = {40'b0, sum_reg[47:32]};
            qdiv_lo  = sum_reg[31:0];
            qdiv_div = {40'b0, bits_reg};
        end
    end

    idi_c2_smul u_smul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (smul_start),
        .mcand   (smul_mcand),
        .mplier  (smul_mplier),
        .product (smul_prod),
        .done    (smul_done)
    );

    idi_c2_qdiv u_qdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (qdiv_start),
        .rem_init (qdiv_rem),
        .num_lo   (qdiv_lo),
        .divisor  (qdiv_div),
        .quotient (qdiv_quot),
        .done     (qdiv_done)
    );

    // Control, configuration and score state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
            min_ivl_reg   <= 40'd0;
            rel_err_reg   <= 24'd6554;
            min_err_reg   <= 40'd1000000;
            junk_reg      <= 32'd6553600;
            sum_reg       <= '0;
            prev_ivl_reg  <= '0;
            pvalid_reg    <= 1'b0;
            have_prev_reg <= 1'b0;
            ptime_reg     <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    idi_c2_pkg::CFG_MIN_INTERVAL: min_ivl_reg <= cfg_data;
                    idi_c2_pkg::CFG_REL_ERROR:    rel_err_reg <= cfg_data[23:0];
                    idi_c2_pkg::CFG_MIN_ERROR:    min_err_reg <= cfg_data;
                    idi_c2_pkg::CFG_JUNK_PENALTY: junk_reg    <= cfg_data[31:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    cnt_reg <= '0;
                    if (s_valid) begin
                        if (s_action) begin
                            sum_reg       <= '0;
                            prev_ivl_reg  <= '0;
                            pvalid_reg    <= 1'b0;
                            have_prev_reg <= 1'b0;
                            ptime_reg     <= '0;
                            state_reg     <= S_DONE;
                        end else if (!s_in_track) begin
                            state_reg <= S_NORM_CHK;
                        end else if (restart) begin
                            have_prev_reg <= 1'b1;
                            ptime_reg     <= s_unit_time;
                            sum_reg       <= '0;
                            state_reg     <= S_DONE;
                        end else begin
                            state_reg <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == MS_LAST) begin
                        state_reg <= S_IVL;
                    end
                end
                S_IVL: begin
                    state_reg <= S_NOW;
                end
                S_NOW: begin
                    if (pvalid_reg) begin
                        state_reg <= S_TERM;
                    end else begin
                        // First interval is only stored.
                        ptime_reg    <= t_reg;
                        prev_ivl_reg <= now_val;
                        pvalid_reg   <= 1'b1;
                        state_reg    <= S_NORM_CHK;
                    end
                end
                S_TERM: begin
                    state_reg <= S_CHK;
                end
                S_CHK: begin
                    state_reg <= (junk || sat_div) ? S_ACC : S_DIV;
                end
                S_DIV: begin
                    if (qdiv_done) begin
                        state_reg <= S_SQR;
                    end
                end
                S_SQR: begin
                    if (smul_done) begin
                        state_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    sum_reg      <= sum_add[48] ? SUM_MAX : sum_add[47:0];
                    ptime_reg    <= t_reg;
                    prev_ivl_reg <= now_reg;
                    pvalid_reg   <= 1'b1;
                    state_reg    <= S_NORM_CHK;
                end
                S_NORM_CHK: begin
                    state_reg <= sat_norm ? S_DONE : S_NORM;
                end
                S_NORM: begin
                    if (qdiv_done) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                t_reg         <= s_unit_time;
                bits_reg      <= s_bit_count;
                sh_p_reg      <= ptime_reg;
                sh_t_reg      <= s_unit_time;
                rp_reg        <= '0;
                rt_reg        <= '0;
                res_score_reg <= '0;
                res_ovf_reg   <= 1'b0;
            end
            S_MOD: begin
                // Both times enter MSB first; only their remainders are kept.
                rp_reg   <= ms_step(rp_reg, sh_p_reg[62]);
                rt_reg   <= ms_step(rt_reg, sh_t_reg[62]);
                sh_p_reg <= {sh_p_reg[61:0], 1'b0};
                sh_t_reg <= {sh_t_reg[61:0], 1'b0};
            end
            S_IVL: begin
                pa_reg   <= ptime_reg - {43'b0, rp_reg};
                ta_reg   <= t_reg - {43'b0, rt_reg};
                dpos_reg <= t_reg - ptime_reg;
                ge_reg   <= (t_reg >= ptime_reg);
            end
            S_NOW: begin
                now_reg <= now_val;
            end
            S_TERM: begin
                a_reg <= d_fwd[48] ? d_bwd[47:0] : d_fwd[47:0];
                e_reg <= (last_pos && (p_err > {15'b0, min_eff})) ? p_err : {15'b0, min_eff};
            end
            S_CHK: begin
                term_reg <= junk ? {16'b0, junk_reg} : SUM_MAX;
            end
            S_SQR: begin
                if (smul_done) begin
                    term_reg <= smul_prod[63:16];
                end
            end
            S_NORM_CHK: begin
                res_score_reg <= SCORE_MAX;
                res_ovf_reg   <= 1'b1;
            end
            S_NORM: begin
                if (qdiv_done) begin
                    res_score_reg <= qdiv_quot;
                    res_ovf_reg   <= (sum_reg == SUM_MAX);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_score_reg <= res_score_reg;
                    m_ovf_reg   <= res_ovf_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_score_q16 = m_score_reg;
    assign m_overflow  = m_ovf_reg;

    // A word in work blocks the input until its result is registered.
    `IDI_C2_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "word taken while busy")
    // The divider finishes only while one of its two uses waits for it.
    `IDI_C2_ASSERT_IMP(a_div_done_state, qdiv_done, (state_reg == S_DIV) || (state_reg == S_NORM), "stray divider result")
    // The multiplier finishes only inside the remainder pass or the square step.
    `IDI_C2_ASSERT_IMP(a_mul_done_state, smul_done, (state_reg == S_MOD) || (state_reg == S_SQR), "stray multiplier result")
    // A stored interval always comes with a stored unit time.
    `IDI_C2_ASSERT_IMP(a_ivl_needs_unit, pvalid_reg, have_prev_reg, "interval without a unit")

endmodule

FILE: tb/idi_chi2_score_checker.sv
`timescale 1ns / 1ps

module idi_chi2_score_checker
    import idi_c2_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_action,
    input  logic [TIME_W-1:0]     s_unit_time,
    input  logic                  s_in_track,
    input  logic [BITS_W-1:0]     s_bit_count,
    input  logic [BITS_W-1:0]     s_k_count,

    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [SCORE_W-1:0]    m_score_q16,
    input  logic                  m_overflow,

    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    output int                    mismatches,
    output int                    outstanding
);

    localparam logic [63:0] NS_PER_MS = 64'd1_000_000;
    localparam logic [63:0] GAP_MAX   = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] SUM_CAP   = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] SCORE_CAP = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               ovf;
    } score_word_t;

    // Register copies.
    logic [MINIVL_W-1:0] gap_floor;
    logic [RELERR_W-1:0] rel_err;
    logic [MINERR_W-1:0] err_floor;
    logic [JUNK_W-1:0]   short_penalty;

    // Track state.
    logic [SUM_W-1:0]    run_sum;
    longint              last_gap;
    logic                last_gap_ok;
    logic                seen_unit;
    logic [TIME_W-1:0]   last_stamp;

    score_word_t pending_scores[$];

    function automatic void clear_track();
        run_sum     = '0;
        last_gap    = 0;
        last_gap_ok = 1'b0;
        seen_unit   = 1'b0;
        last_stamp  = '0;
    endfunction

    // Forward gaps are exact; backward gaps are taken on whole milliseconds.
    // Both are clamped to the signed 48-bit range.
    function automatic longint gap_between(logic [TIME_W-1:0] older, logic [TIME_W-1:0] newer);
        logic [63:0] span;
        if (newer >= older) begin
            span = {1'b0, newer} - {1'b0, older};
            return (span > GAP_MAX) ? longint'(GAP_MAX) : longint'(span);
        end
        span = ({1'b0, older} / NS_PER_MS - {1'b0, newer} / NS_PER_MS) * NS_PER_MS;
        return (span > GAP_MAX) ? -longint'(GAP_MAX) - 1 : -longint'(span);
    endfunction

    // Chi-squared term for one new gap against the previous one, Q16.16.
    function automatic logic [63:0] gap_term(longint prior, longint cur);
        longint      diff;
        logic [63:0] mag;
        logic [63:0] err;
        logic [63:0] pu;
        logic [63:0] scaled;
        logic [63:0] ratio;
        if (cur < longint'({24'd0, gap_floor}))
            return {32'd0, short_penalty};
        diff = cur - prior;
        mag  = (diff < 0) ? -diff : diff;
        err  = (err_floor != '0) ? {24'd0, err_floor} : 64'd1;
        // The relative error only counts against a positive previous gap.
        if (prior > 0) begin
            pu     = prior;
            scaled = pu * {56'd0, rel_err[23:16]} + ((pu * {48'd0, rel_err[15:0]}) >> 16);
            if (scaled > err)
                err = scaled;
        end
        ratio = (mag << 16) / err;
        if (ratio > SCORE_CAP)
            return SUM_CAP;
        return (ratio * ratio) >> 16;
    endfunction

    // Normalized score: running sum over the bit count, saturated.
    function automatic score_word_t score_of(logic [BITS_W-1:0] bits);
        score_word_t w;
        logic [63:0] q;
        if (bits == '0) begin
            w.score = '1;
            w.ovf   = 1'b1;
            return w;
        end
        q       = {16'd0, run_sum} / {48'd0, bits};
        w.ovf   = (q > SCORE_CAP) || (run_sum == SUM_CAP[SUM_W-1:0]);
        w.score = (q > SCORE_CAP) ? '1 : q[SCORE_W-1:0];
        return w;
    endfunction

    // Advances the track state by one input word and returns its score word.
    function automatic score_word_t predict_word(logic act, logic [TIME_W-1:0] t, logic trk,
                                                 logic [BITS_W-1:0] bits, logic [BITS_W-1:0] k);
        score_word_t w;
        longint      gap;
        logic [63:0] grown;
        w = '0;
        if (act) begin
            clear_track();
            return w;
        end
        if (!trk)
            return score_of(bits);
        // Restart keeps the previous gap and its valid flag.
        if (!seen_unit || k <= 1 || bits < 2) begin
            seen_unit  = 1'b1;
            last_stamp = t;
            run_sum    = '0;
            return w;
        end
        gap = gap_between(last_stamp, t);
        if (last_gap_ok) begin
            grown   = {16'd0, run_sum} + gap_term(last_gap, gap);
            run_sum = (grown > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : grown[SUM_W-1:0];
        end
        last_stamp  = t;
        last_gap    = gap;
        last_gap_ok = 1'b1;
        return score_of(bits);
    endfunction

    // Results are checked before new words are predicted, so a word and a result
    // accepted at the same edge never pair up with each other.
    always @(posedge aclk) begin
        score_word_t want;
        if (!aresetn) begin
            gap_floor     = '0;
            rel_err       = 24'd6554;
            err_floor     = 40'd1_000_000;
            short_penalty = 32'd6553600;
            clear_track();
            pending_scores.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_scores.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected score word: score %h overflow %b",
                                 m_score_q16, m_overflow);
                end else begin
                    want = pending_scores.pop_front();
                    if (want.score !== m_score_q16 || want.ovf !== m_overflow) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("score mismatch: expected score %h overflow %b, got score %h overflow %b",
                                     want.score, want.ovf, m_score_q16, m_overflow);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MIN_INTERVAL: gap_floor     = cfg_data[MINIVL_W-1:0];
                    CFG_REL_ERROR:    rel_err       = cfg_data[RELERR_W-1:0];
                    CFG_MIN_ERROR:    err_floor     = cfg_data[MINERR_W-1:0];
                    CFG_JUNK_PENALTY: short_penalty = cfg_data[JUNK_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                pending_scores.push_back(predict_word(s_action, s_unit_time, s_in_track,
                                                      s_bit_count, s_k_count));
        end
        outstanding = pending_scores.size();
    end

endmodule

FILE: tb/idi_chi2_running_score_core_tb.sv
`timescale 1ns / 1ps

module idi_chi2_running_score_core_tb;
    import idi_c2_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int IDLE_PCT    = 18;
    localparam int TAIL_CYCLES = 400;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 155;

    localparam logic ACT_UNIT  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;
    localparam logic TRACK_ON  = 1'b1;
    localparam logic TRACK_OFF = 1'b0;

    localparam logic [TIME_W-1:0] BASE_STAMP = 63'd1_000_000_000;
    localparam logic [TIME_W-1:0] ONE_MS     = 63'd1_000_000;
    localparam logic [TIME_W-1:0] STAMP_TOP  = '1;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_action    = 1'b0;
    logic [TIME_W-1:0]     s_unit_time = '0;
    logic                  s_in_track  = 1'b0;
    logic [BITS_W-1:0]     s_bit_count = '0;
    logic [BITS_W-1:0]     s_k_count   = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [SCORE_W-1:0]    m_score_q16;
    logic                  m_overflow;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index   = CFG_MIN_INTERVAL;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    int mismatches;
    int outstanding;
    int cycles = 0;
    bit quiet  = 1'b0;

    idi_chi2_running_score_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_unit_time (s_unit_time),
        .s_in_track  (s_in_track),
        .s_bit_count (s_bit_count),
        .s_k_count   (s_k_count),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_score_q16 (m_score_q16),
        .m_overflow  (m_overflow),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    idi_chi2_score_checker score_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_unit_time (s_unit_time),
        .s_in_track  (s_in_track),
        .s_bit_count (s_bit_count),
        .s_k_count   (s_k_count),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_score_q16 (m_score_q16),
        .m_overflow  (m_overflow),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("idi_chi2_running_score_core verification failed");
            $finish;
        end
    end

    // Result side stalls at random unless a quiet stretch is running.
    always @(negedge aclk) begin
        m_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic logic [TIME_W-1:0] any_stamp();
        logic [63:0] w = {$urandom, $urandom};
        return w[TIME_W-1:0];
    endfunction

    // Presents one input word, with random idle cycles ahead of it.
    task automatic send_word(input logic act, input logic [TIME_W-1:0] t, input logic trk,
                             input logic [BITS_W-1:0] bits, input logic [BITS_W-1:0] k);
        @(negedge aclk);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_unit_time <= t;
        s_in_track  <= trk;
        s_bit_count <= bits;
        s_k_count   <= k;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stops sending and waits for every predicted score word to come back.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
    endtask

    initial begin
        logic [TIME_W-1:0]     stamp;
        logic [TIME_W-1:0]     hop;
        logic [CFG_DATA_W-1:0] floor_v;
        logic [CFG_DATA_W-1:0] relerr_v;
        logic [CFG_DATA_W-1:0] errfloor_v;
        logic [CFG_DATA_W-1:0] penalty_v;
        logic [BITS_W-1:0]     k_run;
        logic [BITS_W-1:0]     bits;
        int unsigned           base_gap;
        int unsigned           pick;
        int unsigned           shape;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words at the reset settings: zero bit count, clear, first unit,
        // first interval, steady and uneven gaps, time running backwards, restarts.
        send_word(ACT_UNIT, '0, TRACK_OFF, 16'd0, 16'd0);
        send_word(ACT_UNIT, STAMP_TOP, TRACK_OFF, 16'd7, 16'hFFFF);
        send_word(ACT_CLEAR, STAMP_TOP, TRACK_ON, 16'hFFFF, 16'hFFFF);
        send_word(ACT_UNIT, BASE_STAMP, TRACK_ON, 16'd10, 16'd2);
        send_word(ACT_UNIT, BASE_STAMP + 10 * ONE_MS, TRACK_ON, 16'd10, 16'd3);
        send_word(ACT_UNIT, BASE_STAMP + 20 * ONE_MS, TRACK_ON, 16'd10, 16'd4);
        send_word(ACT_UNIT, BASE_STAMP + 33 * ONE_MS, TRACK_ON, 16'd10, 16'd5);
        send_word(ACT_UNIT, BASE_STAMP + 46 * ONE_MS, TRACK_ON, 16'hFFFF, 16'hFFFF);
        send_word(ACT_UNIT, BASE_STAMP + 63'd44_500_000, TRACK_ON, 16'd10, 16'd7);
        send_word(ACT_UNIT, '0, TRACK_OFF, 16'd1, 16'd8);
        send_word(ACT_UNIT, BASE_STAMP + 50 * ONE_MS, TRACK_ON, 16'd10, 16'd1);
        send_word(ACT_UNIT, BASE_STAMP + 60 * ONE_MS, TRACK_ON, 16'd0, 16'd0);
        // Extreme stamps: a gap clamped high, then one clamped low.
        send_word(ACT_UNIT, '0, TRACK_ON, 16'd2, 16'd2);
        send_word(ACT_UNIT, STAMP_TOP, TRACK_ON, 16'd2, 16'd3);
        send_word(ACT_UNIT, 63'd5, TRACK_ON, 16'd2, 16'd4);
        send_word(ACT_UNIT, 63'd5 + 10 * ONE_MS, TRACK_ON, 16'd2, 16'd5);
        send_word(ACT_UNIT, '0, TRACK_OFF, 16'hFFFF, 16'd0);
        drain();

        // Extreme settings: tiny relative and floor errors, largest threshold and penalty.
        write_reg(CFG_MIN_INTERVAL, 40'hFF_FFFF_FFFF);
        write_reg(CFG_REL_ERROR, 40'd1);
        write_reg(CFG_MIN_ERROR, 40'd1);
        write_reg(CFG_JUNK_PENALTY, 40'h00_FFFF_FFFF);
        send_word(ACT_CLEAR, '0, TRACK_ON, 16'd2, 16'd2);
        send_word(ACT_UNIT, '0, TRACK_ON, 16'd2, 16'd2);
        send_word(ACT_UNIT, 63'd1 << 46, TRACK_ON, 16'd2, 16'd3);
        send_word(ACT_UNIT, 63'd1 << 47, TRACK_ON, 16'd2, 16'd4);
        stamp = (63'd1 << 47) + (63'd1 << 45);
        send_word(ACT_UNIT, stamp, TRACK_ON, 16'd2, 16'd5);
        send_word(ACT_UNIT, stamp + 63'd1000, TRACK_ON, 16'd2, 16'd6);
        send_word(ACT_UNIT, stamp + 63'd1000 + (63'd1 << 40), TRACK_ON, 16'd2, 16'd7);
        send_word(ACT_UNIT, '0, TRACK_OFF, 16'hFFFF, 16'd8);

        // Random phases, each under its own register settings.
        k_run = 16'd2;
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: begin
                    floor_v = 40'd0; relerr_v = 40'd6554;
                    errfloor_v = 40'd1_000_000; penalty_v = 40'd6553600;
                end
                1: begin
                    floor_v = 40'd2_000_000; relerr_v = 40'd6554;
                    errfloor_v = 40'd1_000_000; penalty_v = 40'd6553600;
                end
                2: begin
                    floor_v = 40'd0; relerr_v = 40'd1; errfloor_v = 40'd1; penalty_v = 40'd0;
                end
                3: begin
                    floor_v = 40'hFF_FFFF_FFFF; relerr_v = 40'h00_00FF_FFFF;
                    errfloor_v = 40'hFF_FFFF_FFFF; penalty_v = 40'h00_FFFF_FFFF;
                end
                4: begin
                    floor_v = 40'd0; relerr_v = 40'd65536; errfloor_v = 40'd0; penalty_v = 40'd65536;
                end
                5: begin
                    floor_v    = {8'($urandom), $urandom};
                    relerr_v   = {8'($urandom), $urandom};
                    errfloor_v = {8'($urandom), $urandom};
                    penalty_v  = {8'($urandom), $urandom};
                end
                default: begin
                    floor_v    = 40'($urandom_range(0, 5_000_000));
                    relerr_v   = 40'($urandom_range(1, 24'hFF_FFFF));
                    errfloor_v = 40'($urandom_range(1, 50_000_000));
                    penalty_v  = 40'($urandom);
                end
            endcase
            write_reg(CFG_MIN_INTERVAL, floor_v);
            write_reg(CFG_REL_ERROR, relerr_v);
            write_reg(CFG_MIN_ERROR, errfloor_v);
            write_reg(CFG_JUNK_PENALTY, penalty_v);
            base_gap = $urandom_range(2_000, 100_000_000);
            stamp    = any_stamp() >> 2;
            // One whole phase runs with neither side idling.
            quiet = (p == 6);

            for (int n = 0; n < PHASE_WORDS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 2) begin
                    send_word(ACT_CLEAR, any_stamp(), 1'($urandom), 16'($urandom), 16'($urandom));
                end else if (pick < 10) begin
                    bits = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
                    send_word(ACT_UNIT, any_stamp(), TRACK_OFF, bits, 16'($urandom));
                end else if (pick < 14) begin
                    // Noise: a tracked word with nothing kept in order.
                    send_word(ACT_UNIT, any_stamp(), TRACK_ON, 16'($urandom), 16'($urandom));
                end else if (pick < 18) begin
                    if ($urandom_range(0, 1) == 0)
                        send_word(ACT_UNIT, stamp, TRACK_ON, 16'($urandom_range(2, 64)),
                                  16'($urandom_range(0, 1)));
                    else
                        send_word(ACT_UNIT, stamp, TRACK_ON, 16'($urandom_range(0, 1)),
                                  16'($urandom_range(2, 65535)));
                    k_run = 16'd2;
                end else begin
                    // Regular detections with jitter, now and then a short, backward
                    // or huge gap.
                    shape = $urandom_range(0, 99);
                    if (shape < 4)
                        stamp = stamp - 63'($urandom_range(0, 3 * base_gap));
                    else if (shape < 8)
                        stamp = stamp + 63'($urandom_range(0, base_gap / 8));
                    else if (shape == 8)
                        stamp = stamp + any_stamp();
                    else begin
                        hop   = 63'(base_gap - base_gap / 8 + $urandom_range(0, base_gap / 4));
                        stamp = stamp + hop;
                    end
                    k_run = k_run + 16'd1;
                    bits  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(2, 65535))
                                                        : 16'($urandom_range(2, 64));
                    send_word(ACT_UNIT, stamp, TRACK_ON, bits, k_run);
                end
            end
        end

        drain();
        quiet = 1'b0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("idi_chi2_running_score_core verification clean");
        else
            $display("idi_chi2_running_score_core verification failed");
        $finish;
    end

endmodule
